FILE: hdl/stau_pkg.sv
// shared constants, types and angle table of the spherical texel address unit
package stau_pkg;

    // coordinate and result widths
    localparam int CW            = 32;
    localparam int DIM_BITS      = 12;
    localparam int ANGLE_BITS    = 16;
    localparam int SIZE_W        = 13;
    localparam int PITCH_W       = 17;
    localparam int BPT_W         = 3;
    localparam int OFFSET_W      = 28;
    localparam int CFG_W         = 17;

    // iteration counts of the two cell rows
    localparam int SQRT_STEPS    = 32;
    localparam int CORDIC_STEPS  = 30;

    // cordic vector and angle accumulator widths
    localparam int PRE_TOP       = 40;
    localparam int VW            = 45;
    localparam int AW            = 36;

    // register indexes of the configuration port
    localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
    localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROW_PITCH  = 2'd2;
    localparam logic [1:0] REG_BPT        = 2'd3;

    // normalized vector travelling beside the square root row
    typedef struct packed {
        logic                 valid;
        logic                 deg;
        logic signed [CW-1:0] nx;
        logic signed [CW-1:0] ny;
        logic signed [CW-1:0] nz;
    } side_t;

    // square root cell word
    typedef struct packed {
        logic [63:0] n;
        logic [63:0] r;
        side_t       side;
    } sqrt_t;

    // cordic cell word
    typedef struct packed {
        logic                 valid;
        logic                 deg;
        logic                 zero;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [AW-1:0] acc;
    } cord_t;

    // arctangent of 2^-i in units of 2^-32 turn, rounded to nearest
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] a;
        case (i)
            5'd0:    a = 30'h20000000;
            5'd1:    a = 30'h12E4051E;
            5'd2:    a = 30'h09FB385B;
            5'd3:    a = 30'h051111D4;
            5'd4:    a = 30'h028B0D43;
            5'd5:    a = 30'h0145D7E1;
            5'd6:    a = 30'h00A2F61E;
            5'd7:    a = 30'h00517C55;
            5'd8:    a = 30'h0028BE53;
            5'd9:    a = 30'h00145F2F;
            5'd10:   a = 30'h000A2F98;
            5'd11:   a = 30'h000517CC;
            5'd12:   a = 30'h00028BE6;
            5'd13:   a = 30'h000145F3;
            5'd14:   a = 30'h0000A2FA;
            5'd15:   a = 30'h0000517D;
            5'd16:   a = 30'h000028BE;
            5'd17:   a = 30'h0000145F;
            5'd18:   a = 30'h00000A30;
            5'd19:   a = 30'h00000518;
            5'd20:   a = 30'h0000028C;
            5'd21:   a = 30'h00000146;
            5'd22:   a = 30'h000000A3;
            5'd23:   a = 30'h00000051;
            5'd24:   a = 30'h00000029;
            5'd25:   a = 30'h00000014;
            5'd26:   a = 30'h0000000A;
            5'd27:   a = 30'h00000005;
            5'd28:   a = 30'h00000003;
            5'd29:   a = 30'h00000001;
            default: a = 30'h0;
        endcase
        return a;
    endfunction

endpackage

FILE: hdl/stau_front.sv
// front end: saturated difference, common scaling, squares and their sum
module stau_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [stau_pkg::CW-1:0] hit [3],
    input  logic signed [stau_pkg::CW-1:0] centre [3],
    output stau_pkg::sqrt_t                dout
);
    import stau_pkg::*;

    localparam logic signed [CW-1:0] D_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] D_MIN = {1'b1, {(CW-1){1'b0}}};

    logic                   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                   deg2_reg, deg3_reg, deg4_reg, deg5_reg;
    logic signed [CW-1:0]   d1_reg [3];
    logic signed [CW-1:0]   d2_reg [3];
    logic signed [CW-1:0]   n3_reg [3];
    logic signed [CW-1:0]   n4_reg [3];
    logic signed [CW-1:0]   n5_reg [3];
    logic [CW-1:0]          m2_reg;
    logic signed [2*CW-1:0] sqx_reg, sqz_reg;
    logic [63:0]            sum_reg;

    logic signed [CW:0]     diff [3];
    logic signed [CW-1:0]   d1_next [3];
    logic [CW-1:0]          mg [3];
    logic [CW-1:0]          m2_next;
    logic [CW-1:0]          v;
    logic [4:0]             sh;
    logic signed [CW-1:0]   n3_next [3];
    logic signed [2*CW-1:0] sqx_next, sqz_next;

    // saturated differences
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = {hit[i][CW-1], hit[i]} - {centre[i][CW-1], centre[i]};
            if (diff[i][CW] != diff[i][CW-1]) begin
                d1_next[i] = diff[i][CW] ? D_MIN : D_MAX;
            end else begin
                d1_next[i] = diff[i][CW-1:0];
            end
        end
    end

    // magnitudes, or-ed to find the leading bit of the largest one
    always_comb begin
        m2_next = '0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = d1_reg[i][CW-1] ? (~d1_reg[i] + 1'b1) : d1_reg[i];
            m2_next = m2_next | mg[i];
        end
    end

    // shift that brings the largest magnitude to the bit below the sign bit
    always_comb begin
        v  = m2_reg;
        sh = '0;
        if (v[CW-2 -: 16] == '0) begin
            v  = v << 16;
            sh = sh + 5'd16;
        end
        if (v[CW-2 -: 8] == '0) begin
            v  = v << 8;
            sh = sh + 5'd8;
        end
        if (v[CW-2 -: 4] == '0) begin
            v  = v << 4;
            sh = sh + 5'd4;
        end
        if (v[CW-2 -: 2] == '0) begin
            v  = v << 2;
            sh = sh + 5'd2;
        end
        if (v[CW-2] == 1'b0) begin
            sh = sh + 5'd1;
        end
        for (int i = 0; i < 3; i++) begin
            n3_next[i] = m2_reg[CW-1] ? (d2_reg[i] >>> 1) : (d2_reg[i] <<< sh);
        end
    end

    // squares of the horizontal components
    assign sqx_next = n3_reg[0] * n3_reg[0];
    assign sqz_next = n3_reg[2] * n3_reg[2];

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg   <= d1_next;
            d2_reg   <= d1_reg;
            m2_reg   <= m2_next;
            deg2_reg <= (m2_next == '0);
            n3_reg   <= n3_next;
            deg3_reg <= deg2_reg;
            sqx_reg  <= sqx_next;
            sqz_reg  <= sqz_next;
            n4_reg   <= n3_reg;
            deg4_reg <= deg3_reg;
            sum_reg  <= $unsigned(sqx_reg) + $unsigned(sqz_reg);
            n5_reg   <= n4_reg;
            deg5_reg <= deg4_reg;
        end
    end

    assign dout.n          = sum_reg;
    assign dout.r          = '0;
    assign dout.side.valid = v5_reg;
    assign dout.side.deg   = deg5_reg;
    assign dout.side.nx    = n5_reg[0];
    assign dout.side.ny    = n5_reg[1];
    assign dout.side.nz    = n5_reg[2];

endmodule

FILE: hdl/stau_sqrt_cell.sv
// one cell of the square root row: settles one root bit
module stau_sqrt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic [4:0]      idx,
    input  stau_pkg::sqrt_t din,
    output stau_pkg::sqrt_t dout
);
    import stau_pkg::*;

    logic [63:0] b;
    logic [63:0] t;
    sqrt_t       cell_next;
    sqrt_t       cell_reg;

    // restoring step on the remainder and partial root
    always_comb begin
        b         = 64'd1 << (7'd62 - {1'b0, idx, 1'b0});
        t         = din.r + b;
        cell_next = din;
        if (din.n >= t) begin
            cell_next.n = din.n - t;
            cell_next.r = (din.r >> 1) + b;
        end else begin
            cell_next.r = din.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.side.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

FILE: hdl/stau_prescale.sv
// cordic entry: zero test, doubling to full scale and fold into the right half plane
module stau_prescale (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic                         in_deg,
    input  logic signed [stau_pkg::CW:0] y,
    input  logic signed [stau_pkg::CW:0] x,
    output stau_pkg::cord_t              dout
);
    import stau_pkg::*;

    localparam logic signed [AW-1:0] HALF_TURN = AW'(64'd1 << 31);

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 deg1_reg, deg2_reg, deg3_reg;
    logic                 z1_reg, z2_reg, z3_reg;
    logic signed [CW:0]   x1_reg, y1_reg;
    logic [5:0]           k1_reg;
    logic signed [VW-1:0] x2_reg, y2_reg;
    logic signed [VW-1:0] x3_reg, y3_reg;
    logic signed [AW-1:0] acc3_reg;

    logic [CW:0]          ax, ay;
    logic [PRE_TOP:0]     vv;
    logic [5:0]           k1_next;
    logic signed [VW-1:0] x2_next, y2_next;
    logic signed [VW-1:0] x3_next, y3_next;
    logic signed [AW-1:0] acc3_next;

    // doubling count that lifts the larger magnitude to the top bit
    always_comb begin
        ax      = x[CW] ? (~x + 1'b1) : x;
        ay      = y[CW] ? (~y + 1'b1) : y;
        vv      = (PRE_TOP+1)'(ax | ay);
        k1_next = '0;
        if (vv[PRE_TOP -: 32] == '0) begin
            vv      = vv << 32;
            k1_next = k1_next + 6'd32;
        end
        if (vv[PRE_TOP -: 16] == '0) begin
            vv      = vv << 16;
            k1_next = k1_next + 6'd16;
        end
        if (vv[PRE_TOP -: 8] == '0) begin
            vv      = vv << 8;
            k1_next = k1_next + 6'd8;
        end
        if (vv[PRE_TOP -: 4] == '0) begin
            vv      = vv << 4;
            k1_next = k1_next + 6'd4;
        end
        if (vv[PRE_TOP -: 2] == '0) begin
            vv      = vv << 2;
            k1_next = k1_next + 6'd2;
        end
        if (vv[PRE_TOP] == 1'b0) begin
            k1_next = k1_next + 6'd1;
        end
    end

    // apply the doubling
    assign x2_next = VW'(x1_reg) <<< k1_reg;
    assign y2_next = VW'(y1_reg) <<< k1_reg;

    // left half plane starts from half a turn
    always_comb begin
        if (x2_reg[VW-1]) begin
            acc3_next = y2_reg[VW-1] ? -HALF_TURN : HALF_TURN;
            x3_next   = -x2_reg;
            y3_next   = -y2_reg;
        end else begin
            acc3_next = '0;
            x3_next   = x2_reg;
            y3_next   = y2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg   <= x;
            y1_reg   <= y;
            k1_reg   <= k1_next;
            z1_reg   <= ((ax | ay) == '0);
            deg1_reg <= in_deg;
            x2_reg   <= x2_next;
            y2_reg   <= y2_next;
            z2_reg   <= z1_reg;
            deg2_reg <= deg1_reg;
            x3_reg   <= x3_next;
            y3_reg   <= y3_next;
            acc3_reg <= acc3_next;
            z3_reg   <= z2_reg;
            deg3_reg <= deg2_reg;
        end
    end

    assign dout.valid = v3_reg;
    assign dout.deg   = deg3_reg;
    assign dout.zero  = z3_reg;
    assign dout.x     = x3_reg;
    assign dout.y     = y3_reg;
    assign dout.acc   = acc3_reg;

endmodule

FILE: hdl/stau_cordic_cell.sv
// one cordic vectoring cell: rotates toward the x axis by one table angle
module stau_cordic_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic [4:0]      idx,
    input  stau_pkg::cord_t din,
    output stau_pkg::cord_t dout
);
    import stau_pkg::*;

    logic signed [VW-1:0] xs, ys;
    logic signed [AW-1:0] at;
    cord_t                cell_next;
    cord_t                cell_reg;

    // rotate by plus or minus atan(2^-idx)
    always_comb begin
        xs        = din.x >>> idx;
        ys        = din.y >>> idx;
        at        = AW'(atan_turn(idx));
        cell_next = din;
        if (!din.y[VW-1] && (din.y != '0)) begin
            cell_next.x   = din.x + ys;
            cell_next.y   = din.y - xs;
            cell_next.acc = din.acc + at;
        end else begin
            cell_next.x   = din.x - ys;
            cell_next.y   = din.y + xs;
            cell_next.acc = din.acc - at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

FILE: hdl/stau_back.sv
// back end: angles to texture coordinates, clamping, byte offset and output register
module stau_back (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  stau_pkg::cord_t                    ct,
    input  stau_pkg::cord_t                    cp,
    input  logic [stau_pkg::SIZE_W-1:0]        tex_width,
    input  logic [stau_pkg::SIZE_W-1:0]        tex_height,
    input  logic [stau_pkg::PITCH_W-1:0]       row_pitch,
    input  logic [stau_pkg::BPT_W-1:0]         bytes_per_texel,
    output logic                               out_valid,
    output logic [stau_pkg::DIM_BITS-1:0]      out_column,
    output logic [stau_pkg::DIM_BITS-1:0]      out_row,
    output logic [stau_pkg::OFFSET_W-1:0]      out_offset,
    output logic                               out_deg
);
    import stau_pkg::*;

    localparam int QW = AW + 2;
    localparam int PW = SIZE_W + ANGLE_BITS + 1;
    localparam int IW = PW - ANGLE_BITS;
    localparam int P1W = DIM_BITS + PITCH_W;
    localparam int P2W = DIM_BITS + BPT_W;
    localparam int SW = P1W + 1;
    localparam logic signed [QW-1:0] HALF_TURN = QW'(64'd1 << 31);
    localparam logic signed [QW-1:0] FULL_TURN = QW'(64'd1 << 32);
    localparam logic [SIZE_W-1:0]    DIM_MAX   = SIZE_W'((64'd1 << DIM_BITS) - 1);
    localparam logic [SW-1:0]        OFF_MAX   = SW'((64'd1 << OFFSET_W) - 1);

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic                    deg1_reg, deg2_reg, deg3_reg, deg4_reg, dego_reg;
    logic [ANGLE_BITS:0]     ua_reg, va_reg;
    logic [PW-1:0]           pw_reg, ph_reg;
    logic [DIM_BITS-1:0]     col3_reg, row3_reg, col4_reg, row4_reg;
    logic [P1W-1:0]          p1_reg;
    logic [P2W-1:0]          p2_reg;
    logic [DIM_BITS-1:0]     colo_reg, rowo_reg;
    logic [OFFSET_W-1:0]     offo_reg;

    logic signed [AW-1:0]    th, ph;
    logic signed [QW-1:0]    uq, vq;
    logic [DIM_BITS-1:0]     col3_next, row3_next;
    logic [SW-1:0]           sum;
    logic [OFFSET_W-1:0]     off_next;

    // clamp to [0, 1] and keep the angle fraction bits
    function automatic logic [ANGLE_BITS:0] angle_frac(input logic signed [QW-1:0] q);
        logic signed [QW-1:0] c;
        if (q[QW-1]) begin
            c = '0;
        end else if (q > FULL_TURN) begin
            c = FULL_TURN;
        end else begin
            c = q;
        end
        return c[32 -: (ANGLE_BITS+1)];
    endfunction

    // scaled coordinate to index, clamped to size minus one and to DIM_MAX, zero for a zero size
    function automatic logic [DIM_BITS-1:0] clamp_index(input logic [PW-1:0] p,
                                                        input logic [SIZE_W-1:0] size);
        logic [IW-1:0]     idx;
        logic [SIZE_W-1:0] lim;
        logic [IW-1:0]     res;
        idx = p[PW-1:ANGLE_BITS];
        lim = size - 1'b1;
        if (lim > DIM_MAX) begin
            lim = DIM_MAX;
        end
        if (size == '0) begin
            res = '0;
        end else if (idx > IW'(lim)) begin
            res = IW'(lim);
        end else begin
            res = idx;
        end
        return res[DIM_BITS-1:0];
    endfunction

    // longitude and latitude fractions
    always_comb begin
        th = ct.zero ? '0 : ct.acc;
        ph = cp.zero ? '0 : cp.acc;
        uq = HALF_TURN + QW'(th);
        vq = HALF_TURN - (QW'(ph) <<< 1);
    end

    assign col3_next = clamp_index(pw_reg, tex_width);
    assign row3_next = clamp_index(ph_reg, tex_height);

    // offset sum with saturation, zero on a degenerate vector
    always_comb begin
        sum = SW'(p1_reg) + SW'(p2_reg);
        if (sum > OFF_MAX) begin
            off_next = OFF_MAX[OFFSET_W-1:0];
        end else begin
            off_next = sum[OFFSET_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= ct.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ua_reg   <= angle_frac(uq);
            va_reg   <= angle_frac(vq);
            deg1_reg <= ct.deg;
            pw_reg   <= PW'(tex_width) * PW'(ua_reg);
            ph_reg   <= PW'(tex_height) * PW'(va_reg);
            deg2_reg <= deg1_reg;
            col3_reg <= col3_next;
            row3_reg <= row3_next;
            deg3_reg <= deg2_reg;
            p1_reg   <= P1W'(row3_reg) * P1W'(row_pitch);
            p2_reg   <= P2W'(col3_reg) * P2W'(bytes_per_texel);
            col4_reg <= col3_reg;
            row4_reg <= row3_reg;
            deg4_reg <= deg3_reg;
            colo_reg <= deg4_reg ? '0 : col4_reg;
            rowo_reg <= deg4_reg ? '0 : row4_reg;
            offo_reg <= deg4_reg ? '0 : off_next;
            dego_reg <= deg4_reg;
        end
    end

    assign out_valid  = vo_reg;
    assign out_column = colo_reg;
    assign out_row    = rowo_reg;
    assign out_offset = offo_reg;
    assign out_deg    = dego_reg;

endmodule

FILE: hdl/spherical_texel_address_unit.sv
// top level of the spherical texel address unit
// throughput: one word per cycle while the output is not stalled; the 32-cell square root row and the two
// 30-cell cordic rows each settle one step per cycle
// the whole pipeline holds only while a result waits at the output register
// reset (aresetn low, synchronous) clears all valid bits and loads the register defaults
module spherical_texel_address_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // hit_x, hit_y, hit_z, centre_x, centre_y, centre_z
    input  logic [191:0]                  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // texel_column, texel_row, byte_offset, zero pad
    output logic [55:0]                   m_tdata,
    // degenerate
    output logic [0:0]                    m_tuser,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [stau_pkg::CFG_W-1:0]    cfg_wdata
);
    import stau_pkg::*;

    logic [SIZE_W-1:0]    tex_width_reg, tex_height_reg;
    logic [PITCH_W-1:0]   row_pitch_reg;
    logic [BPT_W-1:0]     bpt_reg;

    logic                 en;
    logic signed [CW-1:0] hit [3];
    logic signed [CW-1:0] centre [3];
    sqrt_t                sq_chain [SQRT_STEPS+1];
    cord_t                th_chain [CORDIC_STEPS+1];
    cord_t                ph_chain [CORDIC_STEPS+1];
    side_t                side;
    logic [DIM_BITS-1:0]  column, row;
    logic [OFFSET_W-1:0]  offset;
    logic                 deg;

    // pipeline advances unless a result is stuck at the output
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg  <= SIZE_W'(256);
            tex_height_reg <= SIZE_W'(256);
            row_pitch_reg  <= PITCH_W'(1024);
            bpt_reg        <= BPT_W'(4);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_TEX_WIDTH:  tex_width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_TEX_HEIGHT: tex_height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_ROW_PITCH:  row_pitch_reg  <= cfg_wdata[PITCH_W-1:0];
                REG_BPT:        bpt_reg        <= cfg_wdata[BPT_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the input word
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            hit[i]    = s_tdata[i*CW +: CW];
            centre[i] = s_tdata[(i+3)*CW +: CW];
        end
    end

    stau_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .hit      (hit),
        .centre   (centre),
        .dout     (sq_chain[0])
    );

    // square root row
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        stau_sqrt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .idx     (5'(g)),
            .din     (sq_chain[g]),
            .dout    (sq_chain[g+1])
        );
    end

    assign side = sq_chain[SQRT_STEPS].side;

    // longitude lane: atan2(dz, dx)
    stau_prescale u_pre_theta (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (side.valid),
        .in_deg   (side.deg),
        .y        ({side.nz[CW-1], side.nz}),
        .x        ({side.nx[CW-1], side.nx}),
        .dout     (th_chain[0])
    );

    // latitude lane: atan2(dy, horizontal length)
    stau_prescale u_pre_phi (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (side.valid),
        .in_deg   (side.deg),
        .y        ({side.ny[CW-1], side.ny}),
        .x        ({1'b0, sq_chain[SQRT_STEPS].r[CW-1:0]}),
        .dout     (ph_chain[0])
    );

    // cordic rows
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        stau_cordic_cell u_theta (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .idx     (5'(g)),
            .din     (th_chain[g]),
            .dout    (th_chain[g+1])
        );
        stau_cordic_cell u_phi (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .idx     (5'(g)),
            .din     (ph_chain[g]),
            .dout    (ph_chain[g+1])
        );
    end

    stau_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .ct              (th_chain[CORDIC_STEPS]),
        .cp              (ph_chain[CORDIC_STEPS]),
        .tex_width       (tex_width_reg),
        .tex_height      (tex_height_reg),
        .row_pitch       (row_pitch_reg),
        .bytes_per_texel (bpt_reg),
        .out_valid       (m_tvalid),
        .out_column      (column),
        .out_row         (row),
        .out_offset      (offset),
        .out_deg         (deg)
    );

    // pack the result word
    assign m_tdata = {4'b0, offset, row, column};
    assign m_tuser = deg;

endmodule
